FILE: rtl/core/efbc_pkg.sv
package efbc_pkg;

  localparam int unsigned SampleWidthDef = 24;
  localparam int unsigned StageCountDef  = 8;
  localparam int unsigned MaxStages      = 8;
  localparam int unsigned StageW         = 3;
  localparam int unsigned DiffuseSkip    = 2;

  localparam int unsigned StateW   = 40;
  localparam int unsigned CoefW    = 24;
  localparam int unsigned CoefFrac = 20;
  localparam int unsigned MulAW    = CoefW + 1;
  localparam int unsigned ProdW    = MulAW + StateW;
  localparam int unsigned AccW     = ProdW + 1;
  localparam int unsigned SumW     = AccW + 2;
  localparam int unsigned RndW     = SumW - CoefFrac;
  localparam int unsigned RoundHalf = 1 << (CoefFrac - 1);

  localparam int unsigned FadeLength = 240;
  localparam int unsigned PosW       = 8;
  localparam int unsigned GainW      = 17;
  localparam int unsigned GainRomW   = FadeLength * GainW;
  localparam logic [GainW-1:0] FadeOne = GainW'(65536);
  localparam logic [63:0] Q30One    = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam int unsigned RegIdxW  = 1;
  localparam int unsigned RegDataW = 1;
  localparam logic [RegIdxW-1:0] RegEdition = 1'b0;
  localparam logic [RegIdxW-1:0] RegDiffuse = 1'b1;

  typedef enum logic [2:0] {
    CoefB0,
    CoefB1,
    CoefB2,
    CoefA1,
    CoefA2
  } coef_sel_e;

  typedef struct packed {
    logic                     ov;
    logic signed [StateW-1:0] val;
  } sat_t;

  // [edition][stage][b0 b1 b2 a1 a2], Q3.20
  localparam logic signed [CoefW-1:0] CoefTable [2][MaxStages][5] = '{
    '{
      '{ 24'sd1065244, -24'sd2018822,  24'sd966911, -24'sd2018822,  24'sd983579},
      '{ 24'sd1005525, -24'sd1893821,  24'sd919013, -24'sd1893821,  24'sd875962},
      '{ 24'sd1008072, -24'sd1849302,  24'sd861707, -24'sd1849302,  24'sd821203},
      '{ 24'sd2333925, -24'sd1504340, -24'sd522405, -24'sd1504340,  24'sd762943},
      '{  24'sd494650,  -24'sd383875,  24'sd256005,  -24'sd383875, -24'sd297921},
      '{  24'sd120866,        24'sd0, -24'sd120866, -24'sd1883246,  24'sd844982},
      '{ 24'sd1036023, -24'sd2005332,  24'sd971120, -24'sd2005332,  24'sd958567},
      '{ 24'sd2047070,   24'sd170205, -24'sd700442,   24'sd170205,  24'sd298051}
    },
    '{
      '{ 24'sd1065244, -24'sd2018822,  24'sd966911, -24'sd2018822,  24'sd983579},
      '{ 24'sd1005525, -24'sd1893821,  24'sd919013, -24'sd1893821,  24'sd875962},
      '{ 24'sd1008072, -24'sd1849302,  24'sd861707, -24'sd1849302,  24'sd821203},
      '{ 24'sd2333924, -24'sd1504340, -24'sd522405, -24'sd1504340,  24'sd762943},
      '{  24'sd494650,  -24'sd383875,  24'sd256004,  -24'sd383875, -24'sd297922},
      '{  24'sd120866,        24'sd0, -24'sd120866, -24'sd1883245,  24'sd844982},
      '{ 24'sd1036024, -24'sd2005332,  24'sd971119, -24'sd2005332,  24'sd958567},
      '{ 24'sd2047070,   24'sd170205, -24'sd700443,   24'sd170205,  24'sd298051}
    }
  };

  // Raised-cosine fade-in gains, sin^2 by truncating Q30 Taylor steps, Q1.16
  function automatic logic [GainRomW-1:0] build_gain_rom();
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] g;
    logic [GainRomW-1:0] rom;
    rom = '0;
    for (int j = 0; j < FadeLength; j++) begin
      theta = (64'(j) * HalfPiQ30) / FadeLength;
      x2 = (theta * theta) >> 30;
      t = Q30One;
      t = Q30One - ((x2 * t) >> 30) / 110;
      t = Q30One - ((x2 * t) >> 30) / 72;
      t = Q30One - ((x2 * t) >> 30) / 42;
      t = Q30One - ((x2 * t) >> 30) / 20;
      t = Q30One - ((x2 * t) >> 30) / 6;
      s = (theta * t) >> 30;
      g = (((s * s) >> 30) + 64'd8192) >> 14;
      if (g > 64'd65536) begin
        g = 64'd65536;
      end
      rom[j*GainW +: GainW] = g[GainW-1:0];
    end
    return rom;
  endfunction

  localparam logic [GainRomW-1:0] GainRom = build_gain_rom();

  // floor((v + half) / 2^20) + z, done as one sum
  function automatic logic signed [RndW-1:0] round_add(input logic signed [AccW-1:0] v,
                                                       input logic signed [StateW-1:0] z);
    logic signed [SumW-1:0] sum;
    sum = SumW'(v) + (SumW'(z) <<< CoefFrac) + SumW'(RoundHalf);
    return sum[SumW-1:CoefFrac];
  endfunction

  function automatic sat_t sat_state(input logic signed [RndW-1:0] v);
    sat_t r;
    r.ov = !((&v[RndW-1:StateW-1]) || !(|v[RndW-1:StateW-1]));
    if (r.ov) begin
      r.val = v[RndW-1] ? {1'b1, {(StateW-1){1'b0}}} : {1'b0, {(StateW-1){1'b1}}};
    end else begin
      r.val = v[StateW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/efbc_if.sv
interface efbc_in_if import efbc_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           start_of_signal;

  modport source (output valid, output sample, output start_of_signal, input ready);
  modport sink (input valid, input sample, input start_of_signal, output ready);
endinterface

interface efbc_out_if import efbc_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
  logic                           overflow;

  modport source (output valid, output filtered_sample, output overflow, input ready);
  modport sink (input valid, input filtered_sample, input overflow, output ready);
endinterface

FILE: rtl/core/efbc_ram.sv
module efbc_ram import efbc_pkg::*; #(
  parameter int unsigned WIDTH = 2 * StateW,
  parameter int unsigned DEPTH = StageCountDef,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ear_filter_biquad_cascade.sv
// Channel  Dir  Payload                              Transfer
// in_i     in   sample, start_of_signal              valid && ready
// out_o    out  filtered_sample, overflow            valid && ready
// cfg      in   cfg_idx_i, cfg_wdata_i               cfg_we_i
//
// After the input transfer the sequencer runs the fade, then each stage in turn (a diffuse
// field starts at stage DiffuseSkip), loads the result register and returns to idle.
// A single multiplier runs every product, one for the fade and five per stage, and the
// stage delays sit in one RAM read ahead of each stage.
// Reset clears control and diffuse, sets edition; delay entries are invalidated, not swept.
// in_i takes a new sample only when the sequencer is idle; a stalled out_o holds the
// finished result and the sequencer waits before loading the next one.
module ear_filter_biquad_cascade import efbc_pkg::*; #(
  parameter int unsigned STAGE_COUNT  = StageCountDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  efbc_in_if.sink             in_i,
  efbc_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [RegDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int unsigned RamW    = 2 * StateW;
  localparam int unsigned OutSumW = StateW + 1;
  localparam int unsigned OutShrW = OutSumW - 8;
  localparam logic [AddrW-1:0] LastStage    = AddrW'(STAGE_COUNT - 1);
  localparam logic [AddrW-1:0] DiffuseFirst = AddrW'(DiffuseSkip);
  localparam bit EmptyDiffuse = (STAGE_COUNT <= DiffuseSkip);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StFade = 4'd1;
  localparam logic [3:0] StXin  = 4'd2;
  localparam logic [3:0] StP0   = 4'd3;
  localparam logic [3:0] StP1   = 4'd4;
  localparam logic [3:0] StP2   = 4'd5;
  localparam logic [3:0] StP3   = 4'd6;
  localparam logic [3:0] StP4   = 4'd7;
  localparam logic [3:0] StP5   = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0]              state_q, state_d;
  logic [AddrW-1:0]        stage_q, stage_d;
  logic                    edition_q, diffuse_q;
  logic [PosW-1:0]         pos_q, pos_d, pos_eff;
  logic [GainW-1:0]        gain_q, gain_rd;
  logic [STAGE_COUNT-1:0]  valid_q;
  logic                    rvld_q;
  logic                    ov_q;
  logic                    accept;

  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic signed [StateW-1:0]       x_q, y_q, z1n_q;
  logic signed [ProdW-1:0]        prod_q, prod_d, acc_q;
  logic signed [ProdW-1:0]        fade_sum;
  logic signed [StateW-1:0]       faded;

  logic [StageW-1:0]              coef_stage;
  coef_sel_e                      coef_sel;
  logic signed [CoefW-1:0]        coef_val;
  logic signed [MulAW-1:0]        mul_a;
  logic signed [StateW-1:0]       mul_b;

  logic                    ram_we, ram_re;
  logic [AddrW-1:0]        ram_raddr;
  logic [RamW-1:0]         ram_rdata;
  logic signed [StateW-1:0] z1_old, z2_old;
  sat_t                    y_sat, z1_sat, z2_sat;

  logic signed [OutSumW-1:0]      out_sum;
  logic signed [OutShrW-1:0]      out_shr;
  logic                           out_clip_ov;
  logic signed [SAMPLE_WIDTH-1:0] out_clip;
  logic                           out_load;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_ov_q;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;

  // Fade position and gain for the sample being taken
  assign pos_eff = in_i.start_of_signal ? '0 : pos_q;
  assign pos_d   = (pos_eff < PosW'(FadeLength)) ? pos_eff + PosW'(1) : pos_eff;
  assign gain_rd = (pos_eff < PosW'(FadeLength)) ? GainRom[pos_eff * GainW +: GainW]
                                                   : FadeOne;

  assign coef_val = CoefTable[edition_q][coef_stage][coef_sel];
  assign mul_a    = (state_q == StFade) ? $signed({{(MulAW-GainW){1'b0}}, gain_q})
                                        : MulAW'(coef_val);
  assign prod_d   = mul_a * mul_b;

  assign fade_sum = prod_q + ProdW'(32768);
  assign faded    = {fade_sum[47:16], 8'b0};

  assign z1_old = rvld_q ? ram_rdata[RamW-1:StateW] : '0;
  assign z2_old = rvld_q ? ram_rdata[StateW-1:0] : '0;

  assign y_sat  = sat_state(round_add(AccW'(prod_q), z1_old));
  assign z1_sat = sat_state(round_add(AccW'(acc_q) - AccW'(prod_q), z2_old));
  assign z2_sat = sat_state(round_add(AccW'(acc_q) - AccW'(prod_q), '0));

  // Round the Q.31 cascade output to Q.23 and clip to the sample width
  assign out_sum     = OutSumW'(y_q) + OutSumW'(128);
  assign out_shr     = out_sum[OutSumW-1:8];
  assign out_clip_ov = !((&out_shr[OutShrW-1:SAMPLE_WIDTH-1]) ||
                         !(|out_shr[OutShrW-1:SAMPLE_WIDTH-1]));
  assign out_clip    = !out_clip_ov ? out_shr[SAMPLE_WIDTH-1:0] :
                       out_shr[OutShrW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  always_comb begin
    state_d    = state_q;
    stage_d    = stage_q;
    ram_re     = 1'b0;
    ram_raddr  = stage_q;
    ram_we     = 1'b0;
    coef_stage = StageW'(stage_q);
    coef_sel   = CoefB0;
    mul_b      = x_q;
    out_load   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          state_d = StFade;
          stage_d = diffuse_q ? DiffuseFirst : '0;
        end
      end
      StFade: begin
        mul_b   = StateW'(sample_q);
        ram_re  = 1'b1;
        state_d = StXin;
      end
      StXin: begin
        state_d = (diffuse_q && EmptyDiffuse) ? StOut : StP0;
      end
      StP0: begin
        coef_sel = CoefB0;
        state_d  = StP1;
      end
      StP1: begin
        coef_sel = CoefB1;
        state_d  = StP2;
      end
      StP2: begin
        coef_sel = CoefA1;
        mul_b    = y_q;
        state_d  = StP3;
      end
      StP3: begin
        coef_sel = CoefB2;
        state_d  = StP4;
      end
      StP4: begin
        coef_sel = CoefA2;
        mul_b    = y_q;
        state_d  = StP5;
      end
      StP5: begin
        // write back this stage and start b0 of the next one on its input
        ram_we     = 1'b1;
        coef_sel   = CoefB0;
        coef_stage = StageW'(stage_q + AddrW'(1));
        mul_b      = y_q;
        if (stage_q == LastStage) begin
          state_d = StOut;
        end else begin
          stage_d   = stage_q + AddrW'(1);
          ram_re    = 1'b1;
          ram_raddr = stage_q + AddrW'(1);
          state_d   = StP1;
        end
      end
      StOut: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  efbc_ram #(
    .WIDTH (RamW),
    .DEPTH (STAGE_COUNT)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (stage_q),
    .wdata_i ({z1n_q, z2_sat.val}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      stage_q     <= '0;
      edition_q   <= 1'b1;
      diffuse_q   <= 1'b0;
      pos_q       <= '0;
      valid_q     <= '0;
      rvld_q      <= 1'b0;
      ov_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegEdition: edition_q <= cfg_wdata_i[0];
          RegDiffuse: diffuse_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        pos_q <= pos_d;
        ov_q  <= 1'b0;
        if (in_i.start_of_signal) begin
          valid_q <= '0;
        end
      end
      if (ram_re) begin
        rvld_q <= valid_q[ram_raddr];
      end
      if (state_q == StP1) begin
        ov_q <= ov_q | y_sat.ov;
      end
      if (state_q == StP3) begin
        ov_q <= ov_q | z1_sat.ov;
      end
      if (state_q == StP5) begin
        ov_q <= ov_q | z2_sat.ov;
        valid_q[stage_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      sample_q <= in_i.sample;
      gain_q   <= gain_rd;
    end
    if (state_q == StXin) begin
      x_q <= faded;
      y_q <= faded;
    end
    if (state_q == StP1) begin
      y_q <= y_sat.val;
    end
    if (state_q == StP2 || state_q == StP4) begin
      acc_q <= prod_q;
    end
    if (state_q == StP3) begin
      z1n_q <= z1_sat.val;
    end
    if (state_q == StP5) begin
      x_q <= y_q;
    end
    if (out_load) begin
      out_sample_q <= out_clip;
      out_ov_q     <= ov_q | out_clip_ov;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_sample_q;
  assign out_o.overflow        = out_ov_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input transfer taken while a sample is in flight");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StOut)
    else $error("result register loaded outside the output step");

  a_stage_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StP1 || state_q == StP5) |-> (int'(stage_q) < STAGE_COUNT))
    else $error("stage index beyond the cascade");

  a_no_ram_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (stage_q != ram_raddr))
    else $error("delay RAM read and write hit the same stage");
`endif

endmodule

FILE: tb/ear_filter_biquad_cascade_test.sv
`timescale 1ns / 100ps
module ear_filter_biquad_cascade_test;
  import efbc_pkg::*;

  localparam int unsigned STAGES        = 8;
  localparam int unsigned FADE_LEN      = 240;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_AT       = 120;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam longint unsigned Q30_ONE   = 64'd1 << 30;
  localparam longint unsigned HALF_PI   = 64'd1686629713;
  localparam logic signed [23:0] S_MAX  = 24'sh7fffff;
  localparam logic signed [23:0] S_MIN  = 24'sh800000;

  // [edition][stage][b0 b1 b2 a1 a2], Q3.20
  localparam int FilterCoef [2][8][5] = '{
    '{
      '{1065244, -2018822, 966911, -2018822, 983579},
      '{1005525, -1893821, 919013, -1893821, 875962},
      '{1008072, -1849302, 861707, -1849302, 821203},
      '{2333925, -1504340, -522405, -1504340, 762943},
      '{494650, -383875, 256005, -383875, -297921},
      '{120866, 0, -120866, -1883246, 844982},
      '{1036023, -2005332, 971120, -2005332, 958567},
      '{2047070, 170205, -700442, 170205, 298051}
    },
    '{
      '{1065244, -2018822, 966911, -2018822, 983579},
      '{1005525, -1893821, 919013, -1893821, 875962},
      '{1008072, -1849302, 861707, -1849302, 821203},
      '{2333924, -1504340, -522405, -1504340, 762943},
      '{494650, -383875, 256004, -383875, -297922},
      '{120866, 0, -120866, -1883245, 844982},
      '{1036024, -2005332, 971119, -2005332, 958567},
      '{2047070, 170205, -700443, 170205, 298051}
    }
  };

  typedef enum int {WaveUniform, WaveQuiet, WaveSquare, WaveConstant} wave_e;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               start_of_signal;
  } sample_item_t;

  typedef struct packed {
    logic signed [23:0] filtered_sample;
    logic               overflow;
  } filtered_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = RegEdition;
  logic [RegDataW-1:0] cfg_wdata_i = '0;

  efbc_in_if #(.SAMPLE_WIDTH(24)) sample_ch ();
  efbc_out_if #(.SAMPLE_WIDTH(24)) filtered_ch ();

  ear_filter_biquad_cascade #(
    .STAGE_COUNT (8),
    .SAMPLE_WIDTH(24)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (sample_ch),
    .out_o      (filtered_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // filter state as the block should hold it
  bit          edition_sel = 1'b1;
  bit          diffuse_sel = 1'b0;
  longint      delay_a [STAGES];
  longint      delay_b [STAGES];
  int unsigned fade_pos = 0;

  sample_item_t pending_samples [$];
  filtered_t    filtered_expected [$];

  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned saturated_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned settings_run = 1;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    foreach (delay_a[s]) begin
      delay_a[s] = 0;
      delay_b[s] = 0;
    end
  end

  function automatic longint fade_gain_q16(int unsigned pos);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned g;
    longint unsigned divisor [5];
    divisor = '{110, 72, 42, 20, 6};
    if (pos >= FADE_LEN) return 65536;
    theta = (longint'(pos) * HALF_PI) / FADE_LEN;
    x2 = (theta * theta) >> 30;
    t = Q30_ONE;
    foreach (divisor[k]) t = Q30_ONE - ((x2 * t) >> 30) / divisor[k];
    s = (theta * t) >> 30;
    g = (((s * s) >> 30) + 64'd8192) >> 14;
    return (g > 64'd65536) ? 65536 : longint'(g);
  endfunction

  function automatic longint round_q20(longint sum);
    return (sum + (longint'(1) <<< 19)) >>> 20;
  endfunction

  function automatic longint clamp_bits(longint v, int unsigned bits, inout bit ov);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) begin
      ov = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      ov = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic longint coef_of(int s, coef_sel_e sel);
    return longint'(FilterCoef[edition_sel][s][int'(sel)]);
  endfunction

  function automatic filtered_t predict_filtered(sample_item_t item);
    filtered_t r;
    longint    x;
    longint    y;
    longint    xin;
    bit        ov;
    ov = 1'b0;
    if (item.start_of_signal) begin
      foreach (delay_a[s]) begin
        delay_a[s] = 0;
        delay_b[s] = 0;
      end
      fade_pos = 0;
    end
    x = (longint'(item.sample) * fade_gain_q16(fade_pos) + 32768) >>> 16;
    if (fade_pos < FADE_LEN) fade_pos++;
    y = x <<< 8;
    // a diffuse field leaves the first two stages and their delays alone
    for (int s = (diffuse_sel ? 2 : 0); s < STAGES; s++) begin
      xin = y;
      y = clamp_bits(round_q20(coef_of(s, CoefB0) * xin) + delay_a[s], 40, ov);
      delay_a[s] = clamp_bits(round_q20(coef_of(s, CoefB1) * xin - coef_of(s, CoefA1) * y)
                              + delay_b[s], 40, ov);
      delay_b[s] = clamp_bits(round_q20(coef_of(s, CoefB2) * xin - coef_of(s, CoefA2) * y),
                              40, ov);
    end
    y = clamp_bits((y + 128) >>> 8, 24, ov);
    r.filtered_sample = y[23:0];
    r.overflow = ov;
    return r;
  endfunction

  // sender: one random gap after each item, with bursts of back-to-back transfers
  int unsigned send_gap;
  bit          send_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    sample_item_t item;
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
      sample_ch.sample <= '0;
      sample_ch.start_of_signal <= 1'b0;
      send_gap <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        item.sample = sample_ch.sample;
        item.start_of_signal = sample_ch.start_of_signal;
        filtered_expected.push_back(predict_filtered(item));
        samples_sent <= samples_sent + 1;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          sample_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          item = pending_samples.pop_front();
          sample_ch.valid <= 1'b1;
          sample_ch.sample <= item.sample;
          sample_ch.start_of_signal <= item.start_of_signal;
          if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, 19);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up onto its input
  always @(posedge clk_i) begin
    if (rst_ni && !hold_done && samples_sent == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic note_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] result %0d: %s expected %0d, got %0d",
               $realtime, results_seen, what, want, got);
  endtask

  int unsigned recv_stall;
  bit          recv_burst = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    filtered_t   want;
    int unsigned next_stall;
    if (!rst_ni) begin
      filtered_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      next_stall = (recv_stall != 0) ? recv_stall - 1 : 0;
      if (filtered_ch.valid && filtered_ch.ready) begin
        results_seen++;
        if (filtered_ch.overflow) saturated_seen++;
        if (filtered_expected.size() == 0) begin
          note_mismatch("unrequested result, sample", 0, filtered_ch.filtered_sample);
        end else begin
          want = filtered_expected.pop_front();
          if (filtered_ch.filtered_sample !== want.filtered_sample)
            note_mismatch("filtered_sample", want.filtered_sample,
                          filtered_ch.filtered_sample);
          if (filtered_ch.overflow !== want.overflow)
            note_mismatch("overflow", want.overflow, filtered_ch.overflow);
        end
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        next_stall = recv_burst ? 0 : $urandom_range(0, 19);
      end
      recv_stall <= next_stall;
      filtered_ch.ready <= (hold_left == 0) && (next_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, filtered_expected.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_sample(logic signed [23:0] value, logic start);
    sample_item_t item;
    item.sample = value;
    item.start_of_signal = start;
    pending_samples.push_back(item);
  endtask

  task automatic queue_signal(int unsigned len, wave_e wave, bit fresh);
    int unsigned        half;
    logic signed [23:0] level;
    logic signed [23:0] value;
    half = $urandom_range(1, 6);
    level = 24'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      case (wave)
        WaveUniform: value = 24'($urandom);
        WaveQuiet: value = 24'($signed($urandom_range(0, 511)) - 256);
        WaveSquare: value = ((i / half) % 2) ? S_MIN : S_MAX;
        default: value = level;
      endcase
      queue_sample(value, fresh && i == 0);
    end
  endtask

  task automatic queue_random_signals(int unsigned count);
    int unsigned len;
    while (count != 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(3, 25);
      if (len > count) len = count;
      queue_signal(len, wave_e'($urandom_range(0, 3)), $urandom_range(0, 7) != 0);
      count -= len;
    end
  endtask

  // hold until every sample has gone through and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || sample_ch.valid || filtered_expected.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_registers(bit edition, bit diffuse);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegEdition;
    cfg_wdata_i <= edition;
    @(posedge clk_i);
    cfg_idx_i <= RegDiffuse;
    cfg_wdata_i <= diffuse;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    edition_sel = edition;
    diffuse_sel = diffuse;
    settings_run++;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes straight out of reset, then restarts in mid-stream and on the last sample
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(24'sd0, 1'b0);
    queue_sample(-24'sd1, 1'b0);
    queue_sample(24'sd1, 1'b0);
    queue_sample(24'sh555555, 1'b0);
    queue_sample(24'shaaaaaa, 1'b0);
    for (int i = 0; i < 6; i++) queue_sample(i[0] ? S_MIN : S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b1);
    for (int i = 0; i < 5; i++) queue_sample(i[1] ? S_MIN : S_MAX, 1'b0);
    queue_sample(S_MAX, 1'b1);
    wait_idle();

    // fade in on random samples, then drive full-scale squares past the fade into saturation
    set_registers(1'b0, 1'b0);
    queue_signal(200, WaveUniform, 1'b1);
    queue_signal(50, WaveSquare, 1'b0);
    wait_idle();
    // toggle the diffuse field without a restart: the skipped stages keep their delays
    set_registers(1'b0, 1'b1);
    queue_signal(30, WaveSquare, 1'b0);
    wait_idle();
    set_registers(1'b0, 1'b0);
    queue_signal(20, WaveUniform, 1'b0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      set_registers(!p[0], !p[1]);
      queue_random_signals(38);
      wait_idle();
    end

    repeat (60) @(negedge clk_i);
    $display("filtered %0d samples under %0d register settings, %0d of them saturated",
             results_seen, settings_run, saturated_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
